// ===== hdl/bidirectional_motor_ramp_control_assert.svh =====
// Assertion macros used by bidirectional_motor_ramp_control.sv.
`ifndef BIDIRECTIONAL_MOTOR_RAMP_CONTROL_ASSERT_SVH
`define BIDIRECTIONAL_MOTOR_RAMP_CONTROL_ASSERT_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define BMRC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bmrc assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define BMRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmrc assertion failed");

`endif

// ===== hdl/bmrc_pkg.sv =====
`timescale 1ns / 1ps
package bmrc_pkg;

   localparam int DUTY_W = 8;
   localparam int DB_W   = 7;
   localparam int PROD_W = 15;
   localparam int RSP_W  = 24;
   localparam int ADDR_W = 4;

   localparam logic [1:0] REG_DEADBAND  = 2'd0;
   localparam logic [1:0] REG_MIN_DUTY  = 2'd1;
   localparam logic [1:0] REG_MAX_DUTY  = 2'd2;
   localparam logic [1:0] REG_RAMP_STEP = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef struct packed {
      logic              start;
      logic [DUTY_W-1:0] mul_a;
      logic [DUTY_W-1:0] mul_b;
      logic [DUTY_W-1:0] divisor;
   } md_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quotient;
   } md_stat_type;

endpackage

// ===== hdl/bmrc_muldiv.sv =====
`timescale 1ns / 1ps
module bmrc_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  bmrc_pkg::md_ctrl_type ctrl,
   output bmrc_pkg::md_stat_type stat
);
   import bmrc_pkg::*;

   md_state_type      state_ff, state_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [DUTY_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0] dsh_ff, dsh_in;
   logic [DUTY_W-1:0] quo_ff, quo_in;
   logic              done_ff, done_in;
   logic              ge;

   assign ge = acc_ff >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (ctrl.start) state_in = MD_MUL;
         MD_MUL:  if (cnt_ff == 3'd7) state_in = MD_DIV;
         MD_DIV:  if (cnt_ff == 3'd7) state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            cnt_in    = 3'd0;
            acc_in    = '0;
            mcand_in  = {{(PROD_W-DUTY_W){1'b0}}, ctrl.mul_a};
            mplier_in = ctrl.mul_b;
            dsh_in    = {ctrl.divisor, {(PROD_W-DUTY_W){1'b0}}};
         end
         MD_MUL: begin
            // add one partial product per multiplier bit
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[DUTY_W-1:1]};
            cnt_in    = cnt_ff + 3'd1;
         end
         MD_DIV: begin
            // one quotient bit per cycle, quotient fits in eight bits
            if (ge) acc_in = acc_ff - dsh_ff;
            quo_in  = {quo_ff[DUTY_W-2:0], ge};
            dsh_in  = {1'b0, dsh_ff[PROD_W-1:1]};
            cnt_in  = cnt_ff + 3'd1;
            done_in = cnt_ff == 3'd7;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// ===== hdl/bidirectional_motor_ramp_control.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Fields (low bit first)
// req     | in  | tdata: pot_sample[7:0]
// rsp     | out | tdata: duty[7:0], drive_forward, drive_reverse, pwm_running,
//         |     |        target_duty[7:0], zero pad
// csr     | in  | APB, regs deadband, min_duty, max_duty, ramp_step at 4*i
// Each item goes through these steps from one accept to the next: the accept, 8 multiply and
// 8 divide steps in the bit-serial multiply/divide unit, a pickup of the
// quotient, then one update of duty and direction, which registers the result.
// Reset clears duty and direction and loads the register defaults.
// The result register holds while rsp_tready is low; a new item is accepted,
// but its update waits until the result register is free.
module bidirectional_motor_ramp_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pot_sample[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // duty[7:0], fwd[8], rev[9], run[10], target[18:11]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bmrc_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [DB_W-1:0]   deadband_ff;
   logic [DUTY_W-1:0] min_duty_ff, max_duty_ff, ramp_step_ff;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              fwd_on_ff, fwd_on_in, rev_on_ff, rev_on_in;
   logic              fwd_cmd_ff, inzone_ff;
   logic [DUTY_W-1:0] span_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic              accept, load, out_free, csr_wr;
   logic [DUTY_W-1:0] inv, mag, m, span, target;
   logic              fwd, inzone, running;
   logic [DUTY_W:0]   sum;
   md_ctrl_type       md_ctrl;
   md_stat_type       md_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEADBAND:  csr_prdata = {25'd0, deadband_ff};
         REG_MIN_DUTY:  csr_prdata = {24'd0, min_duty_ff};
         REG_MAX_DUTY:  csr_prdata = {24'd0, max_duty_ff};
         REG_RAMP_STEP: csr_prdata = {24'd0, ramp_step_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= 7'd12;
         min_duty_ff  <= 8'd70;
         max_duty_ff  <= 8'd255;
         ramp_step_ff <= 8'd36;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_DEADBAND:  deadband_ff  <= csr_pwdata[DB_W-1:0];
            REG_MIN_DUTY:  min_duty_ff  <= csr_pwdata[DUTY_W-1:0];
            REG_MAX_DUTY:  max_duty_ff  <= csr_pwdata[DUTY_W-1:0];
            REG_RAMP_STEP: ramp_step_ff <= csr_pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // distance from center, less the deadband
   assign inv    = ~req_tdata;
   assign fwd    = inv[7];
   assign mag    = fwd ? {1'b0, inv[6:0]} : 8'd128 - {1'b0, inv[6:0]};
   assign inzone = mag <= {1'b0, deadband_ff};
   assign m      = mag - {1'b0, deadband_ff};
   assign span   = (max_duty_ff >= min_duty_ff) ? max_duty_ff - min_duty_ff : 8'd0;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign md_ctrl.start   = accept;
   assign md_ctrl.mul_a   = m;
   assign md_ctrl.mul_b   = span;
   assign md_ctrl.divisor = 8'd128 - {1'b0, deadband_ff};

   bmrc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctrl  (md_ctrl),
      .stat  (md_stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CALC;
         ST_CALC: if (md_stat.done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_CALC: ;
         ST_DONE: load = out_free;
         default: ;
      endcase
   end

   assign target  = inzone_ff ? 8'd0 : md_stat.quotient + min_duty_ff;
   assign running = fwd_on_ff || rev_on_ff;
   assign sum     = {1'b0, duty_ff} + {1'b0, ramp_step_ff};

   always_comb begin
      duty_in   = duty_ff;
      fwd_on_in = fwd_on_ff;
      rev_on_in = rev_on_ff;
      priority if (running && (duty_ff > target || fwd_on_ff != fwd_cmd_ff)) begin
         if (duty_ff <= ramp_step_ff) begin
            fwd_on_in = 1'b0;
            rev_on_in = 1'b0;
         end else begin
            duty_in = duty_ff - ramp_step_ff;
         end
      end else if (target != 8'd0 && !running) begin
         duty_in = ramp_step_ff;
         if (fwd_cmd_ff) fwd_on_in = 1'b1;
         else rev_on_in = 1'b1;
      end else if (duty_ff < target) begin
         duty_in = (sum > {1'b0, target}) ? target : sum[DUTY_W-1:0];
      end else begin
         duty_in = duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         duty_ff      <= '0;
         fwd_on_ff    <= 1'b0;
         rev_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            duty_ff      <= duty_in;
            fwd_on_ff    <= fwd_on_in;
            rev_on_ff    <= rev_on_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         fwd_cmd_ff <= fwd;
         inzone_ff  <= inzone;
         span_ff    <= span;
      end
      if (load) begin
         rsp_data_ff <= {5'd0, target, fwd_on_in || rev_on_in, rev_on_in, fwd_on_in, duty_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "bidirectional_motor_ramp_control_assert.svh"

   `BMRC_ASSERT_ALWAYS(a_dir_excl, clock, reset, !(fwd_on_ff && rev_on_ff))
   `BMRC_ASSERT_IMP(a_quo_span, clock, reset, md_stat.done && !inzone_ff, md_stat.quotient <= span_ff)
   `BMRC_ASSERT_IMP(a_load_src, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

// ===== bench/tb_bidirectional_motor_ramp_control.sv =====
`timescale 1ns / 1ps
module tb_bidirectional_motor_ramp_control;
   import bmrc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [7:0] target;
      logic       run;
      logic       rev;
      logic       fwd;
      logic [7:0] duty;
   } tick_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // pot_sample[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // duty[7:0], fwd, rev, run, target[7:0], zero pad
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [6:0] cfg_deadband = 7'd12;
   logic [7:0] cfg_min_duty = 8'd70;
   logic [7:0] cfg_max_duty = 8'd255;
   logic [7:0] cfg_ramp_step = 8'd36;

   logic [7:0] motor_duty = 8'd0;
   logic       motor_fwd = 1'b0;
   logic       motor_rev = 1'b0;

   tick_result_type expected_ticks[$];
   int error_count = 0;
   int cycle_count = 0;
   logic steady = 1'b0;

   bidirectional_motor_ramp_control u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic tick_result_type predict_tick(input logic [7:0] sample);
      tick_result_type r;
      int unsigned inv, mag, span, tgt, nxt;
      logic want_fwd, running;
      inv = 255 - sample;
      want_fwd = (inv >= 128);
      mag = want_fwd ? inv - 128 : 128 - inv;
      if (mag <= cfg_deadband) begin
         tgt = 0;
      end else begin
         span = (cfg_max_duty >= cfg_min_duty) ? cfg_max_duty - cfg_min_duty : 0;
         tgt = ((mag - cfg_deadband) * span / (128 - cfg_deadband) + cfg_min_duty) & 255;
      end
      running = motor_fwd || motor_rev;
      if (running && (motor_duty > tgt || motor_fwd != want_fwd)) begin
         if (motor_duty <= cfg_ramp_step) begin
            motor_fwd = 1'b0;
            motor_rev = 1'b0;
         end else begin
            motor_duty = motor_duty - cfg_ramp_step;
         end
      end else if (tgt > 0 && !running) begin
         motor_duty = cfg_ramp_step;
         if (want_fwd) motor_fwd = 1'b1;
         else motor_rev = 1'b1;
      end else if (motor_duty < tgt) begin
         nxt = motor_duty + cfg_ramp_step;
         motor_duty = 8'((nxt > tgt) ? tgt : nxt);
      end
      r.duty = motor_duty;
      r.fwd = motor_fwd;
      r.rev = motor_rev;
      r.run = motor_fwd || motor_rev;
      r.target = tgt[7:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      if (error_count < PRINT_CAP)
         $display("mismatch on %s: got %0d, want %0d (cycle %0d)",
                  field, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      tick_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = tick_result_type'(rsp_tdata[18:0]);
            if (expected_ticks.size() == 0) begin
               report_mismatch("unexpected item duty", got.duty, -1);
            end else begin
               want = expected_ticks.pop_front();
               if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
               if (got.fwd !== want.fwd) report_mismatch("drive_forward", got.fwd, want.fwd);
               if (got.rev !== want.rev) report_mismatch("drive_reverse", got.rev, want.rev);
               if (got.run !== want.run) report_mismatch("pwm_running", got.run, want.run);
               if (got.target !== want.target)
                  report_mismatch("target_duty", got.target, want.target);
            end
         end
         if (req_tvalid && req_tready) expected_ticks.push_back(predict_tick(req_tdata));
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(0, 99) >= 12);
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_sample(input logic [7:0] sample);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DEADBAND:  cfg_deadband = val[6:0];
         REG_MIN_DUTY:  cfg_min_duty = val[7:0];
         REG_MAX_DUTY:  cfg_max_duty = val[7:0];
         REG_RAMP_STEP: cfg_ramp_step = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [6:0] db, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] step);
      drain_results();
      csr_write(REG_DEADBAND, {25'd0, db});
      csr_write(REG_MIN_DUTY, {24'd0, lo});
      csr_write(REG_MAX_DUTY, {24'd0, hi});
      csr_write(REG_RAMP_STEP, {24'd0, step});
   endtask

   task automatic test_reset_defaults();
      logic [7:0] samples[10] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                  8'd255, 8'd255, 8'd255, 8'd127, 8'd128};
      foreach (samples[i]) send_sample(samples[i]);
   endtask

   task automatic test_max_below_min();
      apply_config(7'd12, 8'd200, 8'd100, 8'd36);
      send_sample(8'd0);
      send_sample(8'd0);
      send_sample(8'd255);
   endtask

   task automatic test_zero_span();
      apply_config(7'd12, 8'd0, 8'd0, 8'd36);
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd0);
   endtask

   task automatic test_start_above_target();
      apply_config(7'd0, 8'd10, 8'd20, 8'd255);
      send_sample(8'd127);
      send_sample(8'd0);
      send_sample(8'd0);
      send_sample(8'd0);
   endtask

   task automatic test_deadband_extremes();
      apply_config(7'd127, 8'd0, 8'd255, 8'd1);
      send_sample(8'd255);
      send_sample(8'd254);
      apply_config(7'd0, 8'd0, 8'd255, 8'd1);
      send_sample(8'd127);
      send_sample(8'd126);
   endtask

   task automatic run_random_ticks(input int count, input bit pause_midway);
      int n, mode, len;
      logic [7:0] level, sample;
      n = 0;
      while (n < count) begin
         mode = $urandom_range(0, 9);
         level = 8'($urandom_range(0, 255));
         len = $urandom_range(1, 16);
         for (int k = 0; k < len && n < count; k++) begin
            if (mode < 2) sample = 8'($urandom_range(0, 255));
            else if (mode < 4) sample = 8'(level + $urandom_range(0, 6) - 3);
            else sample = level;
            send_sample(sample);
            n++;
            if (pause_midway && n == count / 2) drain_results();
         end
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_config(7'd12, 8'd70, 8'd255, 8'd36);
            1: apply_config(7'd0, 8'd0, 8'd255, 8'd1);
            2: apply_config(7'd127, 8'd255, 8'd255, 8'd255);
            3: apply_config(7'd64, 8'd255, 8'd0, 8'd8);
            4: apply_config(7'd5, 8'd0, 8'd0, 8'd128);
            default: apply_config(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
         endcase
         steady = (p == 1);
         run_random_ticks(95, p == 3);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_max_below_min();
      test_zero_span();
      test_start_above_target();
      test_deadband_extremes();
      test_random_phases();
      drain_results();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
